// File: hdl/ptmi_pkg.sv
// Shared types, constants and helpers for the page table map insert block.
`timescale 1ns / 1ps
package ptmi_pkg;

  localparam int VA_W       = 48;
  localparam int PA_W       = 48;
  localparam int FLAGS_W    = 64;
  localparam int FRAME_W    = 36;
  localparam int DESC_W     = 64;
  localparam int IDX_W      = 9;
  localparam int LVL_W      = 2;
  localparam int VROW_W     = 64;
  localparam int VBIT_W     = 6;
  localparam int ROW_SEL_W  = 3;
  localparam int ROWS_PER_TABLE = 8;
  localparam int STATUS_W   = 2;
  localparam int ADDED_W    = 2;

  localparam logic [LVL_W-1:0]  LEAF_LVL       = 2'd3;
  localparam logic [1:0]        DESC_TYPE_TP   = 2'b11;
  localparam logic [DESC_W-1:0] DESC_TYPE_BITS = 64'h0000_0000_0000_0003;
  localparam logic [DESC_W-1:0] DESC_AF        = 64'h0000_0000_0000_0400;
  localparam logic [DESC_W-1:0] DESC_ATTR1     = 64'h0000_0000_0000_0004;
  localparam logic [DESC_W-1:0] DESC_PXN       = 64'h0020_0000_0000_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_MAPPED    = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_CLEAR,
    S_POST
  } state_t;

  typedef struct packed {
    logic    load;
    logic    wr_leaf;
    logic    alloc;
    logic    descend;
    logic    clr_row;
    logic    st_we;
    status_t st_code;
    logic    post;
  } cmd_t;

  typedef struct packed {
    logic vbit;
    logic leaf;
    logic table_type;
    logic rel_ok;
    logic pool_full;
    logic clr_last;
  } sts_t;

  // Nine address bits that index the table at a given level.
  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                input logic [LVL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// File: hdl/ptmi_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module ptmi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ptmi_dp.sv
// Datapath: request registers, table and valid-bit memories, pool allocator, result.
`timescale 1ns / 1ps
module ptmi_dp #(
  parameter int MAX_TABLES = 16,
  parameter int LEVELS     = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ptmi_pkg::cmd_t                     cmd,
  output ptmi_pkg::sts_t                     sts,
  input  logic                               cfg_we,
  input  logic [ptmi_pkg::FRAME_W-1:0]       cfg_frame,
  input  logic [ptmi_pkg::VA_W-1:0]          in_va,
  input  logic [ptmi_pkg::PA_W-1:0]          in_pa,
  input  logic [ptmi_pkg::FLAGS_W-1:0]       in_flags,
  output logic [ptmi_pkg::STATUS_W-1:0]      out_status,
  output logic [ptmi_pkg::ADDED_W-1:0]       out_added
);

  localparam int TBL_W   = $clog2(MAX_TABLES);
  localparam int NF_W    = $clog2(MAX_TABLES + 1);
  localparam int EADDR_W = TBL_W + ptmi_pkg::IDX_W;
  localparam int VADDR_W = TBL_W + ptmi_pkg::ROW_SEL_W;
  localparam logic [ptmi_pkg::LVL_W-1:0] LVL_START = ptmi_pkg::LVL_W'(4 - LEVELS);

  logic [ptmi_pkg::VA_W-1:0]     va_r;
  logic [ptmi_pkg::PA_W-1:0]     pa_r;
  logic [ptmi_pkg::FLAGS_W-1:0]  flags_r;
  logic [TBL_W-1:0]              table_r;
  logic [ptmi_pkg::LVL_W-1:0]    lvl_r;
  logic [NF_W-1:0]               next_free_r;
  logic [ptmi_pkg::ADDED_W-1:0]  added_r;
  ptmi_pkg::status_t             status_r;
  logic [ptmi_pkg::FRAME_W-1:0]  pool_base_r;
  logic [TBL_W-1:0]              clr_tbl_r;
  logic [ptmi_pkg::ROW_SEL_W-1:0] clr_cnt_r;
  logic [ptmi_pkg::STATUS_W-1:0] out_status_r;
  logic [ptmi_pkg::ADDED_W-1:0]  out_added_r;

  logic [ptmi_pkg::IDX_W-1:0]    idx;
  logic [EADDR_W-1:0]            e_addr;
  logic [VADDR_W-1:0]            v_addr;
  logic [ptmi_pkg::DESC_W-1:0]   entry_rd;
  logic [ptmi_pkg::VROW_W-1:0]   vrow_rd;
  logic [ptmi_pkg::FRAME_W-1:0]  rel;
  logic [ptmi_pkg::FRAME_W-1:0]  new_frame;
  logic [ptmi_pkg::DESC_W-1:0]   leaf_desc;
  logic [ptmi_pkg::DESC_W-1:0]   table_desc;
  logic                          e_we;
  logic [ptmi_pkg::DESC_W-1:0]   e_wdata;
  logic                          v_we;
  logic [VADDR_W-1:0]            v_waddr;
  logic [ptmi_pkg::VROW_W-1:0]   v_wdata;

  always_comb begin
    idx        = ptmi_pkg::va_index(va_r, lvl_r);
    e_addr     = {table_r, idx};
    v_addr     = {table_r, idx[ptmi_pkg::IDX_W-1:ptmi_pkg::VBIT_W]};
    rel        = entry_rd[47:12] - pool_base_r;
    new_frame  = pool_base_r + ptmi_pkg::FRAME_W'(next_free_r);
    leaf_desc  = {16'd0, pa_r} | ptmi_pkg::DESC_PXN | ptmi_pkg::DESC_AF |
                 ptmi_pkg::DESC_ATTR1 | ptmi_pkg::DESC_TYPE_BITS | flags_r;
    table_desc = {16'd0, new_frame, 12'd0} | ptmi_pkg::DESC_AF |
                 ptmi_pkg::DESC_ATTR1 | ptmi_pkg::DESC_TYPE_BITS;

    e_we    = cmd.wr_leaf | cmd.alloc;
    e_wdata = cmd.wr_leaf ? leaf_desc : table_desc;

    v_we    = cmd.wr_leaf | cmd.alloc | cmd.clr_row;
    v_waddr = cmd.clr_row ? {clr_tbl_r, clr_cnt_r} : v_addr;
    v_wdata = cmd.clr_row ? '0 :
              (vrow_rd | (ptmi_pkg::VROW_W'(1) << idx[ptmi_pkg::VBIT_W-1:0]));

    sts.vbit       = vrow_rd[idx[ptmi_pkg::VBIT_W-1:0]];
    sts.leaf       = (lvl_r == ptmi_pkg::LEAF_LVL);
    sts.table_type = (entry_rd[1:0] == ptmi_pkg::DESC_TYPE_TP);
    sts.rel_ok     = (rel < ptmi_pkg::FRAME_W'(next_free_r));
    sts.pool_full  = (next_free_r >= NF_W'(MAX_TABLES));
    sts.clr_last   = (clr_cnt_r == ptmi_pkg::ROW_SEL_W'(ptmi_pkg::ROWS_PER_TABLE - 1));
  end

  ptmi_ram #(
    .WIDTH(ptmi_pkg::DESC_W),
    .DEPTH(MAX_TABLES * 512)
  ) u_entry_ram (
    .clk  (clk),
    .we   (e_we),
    .waddr(e_addr),
    .wdata(e_wdata),
    .raddr(e_addr),
    .rdata(entry_rd)
  );

  ptmi_ram #(
    .WIDTH(ptmi_pkg::VROW_W),
    .DEPTH(MAX_TABLES * ptmi_pkg::ROWS_PER_TABLE)
  ) u_valid_ram (
    .clk  (clk),
    .we   (v_we),
    .waddr(v_waddr),
    .wdata(v_wdata),
    .raddr(v_addr),
    .rdata(vrow_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= NF_W'(1);
      pool_base_r <= '0;
      clr_tbl_r   <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_we) begin
        pool_base_r <= cfg_frame;
      end
      if (cmd.alloc) begin
        next_free_r <= next_free_r + NF_W'(1);
        clr_tbl_r   <= next_free_r[TBL_W-1:0];
      end
      if (cmd.clr_row) begin
        clr_cnt_r <= clr_cnt_r + ptmi_pkg::ROW_SEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_r    <= in_va;
      pa_r    <= in_pa;
      flags_r <= in_flags;
      table_r <= '0;
      lvl_r   <= LVL_START;
      added_r <= '0;
    end else if (cmd.alloc) begin
      table_r <= next_free_r[TBL_W-1:0];
      lvl_r   <= lvl_r + ptmi_pkg::LVL_W'(1);
      added_r <= added_r + ptmi_pkg::ADDED_W'(1);
    end else if (cmd.descend) begin
      table_r <= rel[TBL_W-1:0];
      lvl_r   <= lvl_r + ptmi_pkg::LVL_W'(1);
    end
    if (cmd.st_we) begin
      status_r <= cmd.st_code;
    end
    if (cmd.post) begin
      out_status_r <= status_r;
      out_added_r  <= added_r;
    end
  end

  assign out_status = out_status_r;
  assign out_added  = out_added_r;

`ifndef SYNTH
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= NF_W'(MAX_TABLES))
    else $error("free table index ran past the pool");

  a_alloc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |-> !sts.pool_full && !sts.vbit && !sts.leaf)
    else $error("table taken from an exhausted pool or for a present entry");

  a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.alloc |=> next_free_r == $past(next_free_r) + NF_W'(1))
    else $error("pool allocation did not advance by one");

  a_leaf_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_leaf |-> sts.leaf && !sts.vbit)
    else $error("leaf written over a present entry or above the last level");
`endif

endmodule

// File: hdl/ptmi_ctrl.sv
// Controller: sequences the walk, table allocation, clearing and result handoff.
`timescale 1ns / 1ps
module ptmi_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ptmi_pkg::sts_t sts,
  output ptmi_pkg::cmd_t cmd
);

  ptmi_pkg::state_t state_r;
  ptmi_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptmi_pkg::S_INIT:  if (sts.clr_last) state_nxt = ptmi_pkg::S_IDLE;
      ptmi_pkg::S_IDLE:  if (in_valid) state_nxt = ptmi_pkg::S_READ;
      ptmi_pkg::S_READ:  state_nxt = ptmi_pkg::S_CHECK;
      ptmi_pkg::S_CHECK: begin
        if (!sts.vbit) begin
          if (sts.leaf || sts.pool_full) begin
            state_nxt = ptmi_pkg::S_POST;
          end else begin
            state_nxt = ptmi_pkg::S_CLEAR;
          end
        end else if (sts.leaf || !sts.table_type || !sts.rel_ok) begin
          state_nxt = ptmi_pkg::S_POST;
        end else begin
          state_nxt = ptmi_pkg::S_READ;
        end
      end
      ptmi_pkg::S_CLEAR: if (sts.clr_last) state_nxt = ptmi_pkg::S_READ;
      ptmi_pkg::S_POST:  if (out_free) state_nxt = ptmi_pkg::S_IDLE;
      default:           state_nxt = ptmi_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ptmi_pkg::S_INIT:  cmd.clr_row = 1'b1;
      ptmi_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ptmi_pkg::S_READ:  ;
      ptmi_pkg::S_CHECK: begin
        if (!sts.vbit) begin
          if (sts.leaf) begin
            cmd.wr_leaf = 1'b1;
            cmd.st_we   = 1'b1;
            cmd.st_code = ptmi_pkg::ST_MAPPED;
          end else if (sts.pool_full) begin
            cmd.st_we   = 1'b1;
            cmd.st_code = ptmi_pkg::ST_EXHAUSTED;
          end else begin
            cmd.alloc = 1'b1;
          end
        end else if (sts.leaf || !sts.table_type || !sts.rel_ok) begin
          cmd.st_we   = 1'b1;
          cmd.st_code = ptmi_pkg::ST_PRESENT;
        end else begin
          cmd.descend = 1'b1;
        end
      end
      ptmi_pkg::S_CLEAR: cmd.clr_row = 1'b1;
      ptmi_pkg::S_POST:  cmd.post = out_free;
      default:           ;
    endcase
  end

  always_comb begin
    if (cmd.post) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptmi_pkg::S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hdl/page_table_map_insert.sv
// Top level of the page table map insert block: ports, controller and datapath.
`timescale 1ns / 1ps
// Each transaction on the in_ channel maps one 4 KiB page into a four-level
// translation table held in an internal table memory (MAX_TABLES tables of 512
// 64-bit descriptors, with one valid bit per descriptor). The walk starts at
// pool table 0, indexes each level with nine bits of in_virt_addr, creates any
// missing intermediate table from the pool (tables are handed out in order,
// at frames cfg_pool_base_frame + n) and writes the leaf page descriptor. An
// existing leaf, a block descriptor on the path, or a table descriptor whose
// frame does not name an allocated pool table leaves the table untouched and
// reports status 1; running out of pool tables reports status 2, keeping any
// tables already created. One result transaction follows each request. After
// reset the root table's valid bits are cleared row by row, during which no
// request is taken. A request then walks each level as a read of the table
// memory, then a check and write; each new table has its valid bits cleared
// one 64-bit row per cycle before the walk goes on, and the result is posted
// once the output register is free. The block then returns to idle before
// the next acceptance. The single read port of the table memory and the
// dependence of each level's address on the previous level's descriptor
// keep the walk serial; one request is in flight at a time, and the next one
// is accepted in the cycle after the result is registered, even if the
// consumer has not yet taken it. cfg_ready is always high; write the pool
// base only while no request is in flight.
module page_table_map_insert #(
  parameter int MAX_TABLES = 16,
  parameter int LEVELS     = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ptmi_pkg::FRAME_W-1:0]      cfg_pool_base_frame,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ptmi_pkg::VA_W-1:0]         in_virt_addr,
  input  logic [ptmi_pkg::PA_W-1:0]         in_phys_addr,
  input  logic [ptmi_pkg::FLAGS_W-1:0]      in_attr_flags,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ptmi_pkg::STATUS_W-1:0]     out_status,
  output logic [ptmi_pkg::ADDED_W-1:0]      out_tables_added
);

  ptmi_pkg::cmd_t cmd;
  ptmi_pkg::sts_t sts;

  // The pool base register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  ptmi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptmi_dp #(
    .MAX_TABLES(MAX_TABLES),
    .LEVELS    (LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid),
    .cfg_frame (cfg_pool_base_frame),
    .in_va     (in_virt_addr),
    .in_pa     (in_phys_addr),
    .in_flags  (in_attr_flags),
    .out_status(out_status),
    .out_added (out_tables_added)
  );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for page_table_map_insert: random and directed map requests.
`timescale 1ns / 1ps

localparam int TB_MAX_TABLES = 16;
localparam int TB_LEVELS     = 4;
localparam int TB_DEPTH      = TB_MAX_TABLES * 512;

typedef struct {
  ptmi_pkg::status_t status;
  logic [1:0]        added;
} map_result_t;

// Track the table store, predict each map result and compare.
class map_scoreboard;
  logic [63:0]  desc_mem [TB_DEPTH];
  bit           desc_vld [TB_DEPTH];
  int unsigned  next_tbl;
  logic [35:0]  pool_base;
  map_result_t  expected_results [$];
  logic [47:0]  mapped_pages [$];
  int           errors;

  function new();
    next_tbl  = 1;
    pool_base = '0;
    errors    = 0;
  endfunction

  function void set_base(logic [35:0] v);
    pool_base = v;
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  // Walk the tables for one request, update the store, queue the result.
  function void note_request(logic [47:0] va, logic [47:0] pa, logic [63:0] fl);
    int unsigned tbl;
    int unsigned t;
    int          lvl;
    int          a;
    logic [8:0]  idx;
    logic [63:0] e;
    logic [35:0] rel;
    logic [35:0] frame;
    map_result_t r;
    tbl = 0;
    r.status = ptmi_pkg::ST_PRESENT;
    r.added  = 2'd0;
    for (lvl = 4 - TB_LEVELS; lvl < 4; lvl++) begin
      idx = va[(39 - 9 * lvl) +: 9];
      a = tbl * 512 + idx;
      if (!desc_vld[a]) begin
        if (lvl == 3) begin
          desc_mem[a] = {16'h0, pa} | ptmi_pkg::DESC_PXN | ptmi_pkg::DESC_AF |
                        ptmi_pkg::DESC_ATTR1 | ptmi_pkg::DESC_TYPE_BITS | fl;
          desc_vld[a] = 1'b1;
          r.status = ptmi_pkg::ST_MAPPED;
          break;
        end
        if (next_tbl >= TB_MAX_TABLES) begin
          r.status = ptmi_pkg::ST_EXHAUSTED;
          break;
        end
        t = next_tbl;
        frame = pool_base + 36'(t);
        next_tbl = t + 1;
        r.added = r.added + 2'd1;
        // A fresh table starts with every entry invalid.
        for (int i = 0; i < 512; i++) desc_vld[t * 512 + i] = 1'b0;
        desc_mem[a] = {16'h0, frame, 12'h0} | ptmi_pkg::DESC_AF |
                      ptmi_pkg::DESC_ATTR1 | ptmi_pkg::DESC_TYPE_BITS;
        desc_vld[a] = 1'b1;
      end
      if (lvl == 3) break;
      e = desc_mem[a];
      if (e[1:0] != ptmi_pkg::DESC_TYPE_TP) break;
      rel = e[47:12] - pool_base;
      if (rel >= 36'(next_tbl) || rel >= 36'(TB_MAX_TABLES)) break;
      tbl = 32'(rel);
    end
    expected_results.push_back(r);
    if (r.status == ptmi_pkg::ST_MAPPED) mapped_pages.push_back(va);
  endfunction

  function void check_result(logic [1:0] st, logic [1:0] ad);
    map_result_t r;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result: status %0d added %0d", st, ad);
      return;
    end
    r = expected_results.pop_front();
    if (st !== r.status || ad !== r.added) begin
      errors++;
      if (errors <= 10)
        $display("result mismatch: status exp %0d got %0d, added exp %0d got %0d",
                 r.status, st, r.added, ad);
    end
  endfunction
endclass

module tb_top;
  localparam int          HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES = 40;
  localparam int          LIMIT       = 400000;
  localparam logic [35:0] BASE_MAX    = 36'hF_FFFF_FFFF;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [ptmi_pkg::FRAME_W-1:0]  cfg_pool_base_frame;
  logic                          in_valid;
  logic                          in_ready;
  logic [ptmi_pkg::VA_W-1:0]     in_virt_addr;
  logic [ptmi_pkg::PA_W-1:0]     in_phys_addr;
  logic [ptmi_pkg::FLAGS_W-1:0]  in_attr_flags;
  logic                          out_valid;
  logic                          out_ready;
  logic [ptmi_pkg::STATUS_W-1:0] out_status;
  logic [ptmi_pkg::ADDED_W-1:0]  out_tables_added;

  map_scoreboard sb;
  bit            hold_req;   // ask the receiver for one long hold-off
  bit            hold_done;  // the receiver has served the hold-off
  bit            quiet;      // no idling on either side
  int            cycles = 0;

  page_table_map_insert #(
    .MAX_TABLES(TB_MAX_TABLES),
    .LEVELS    (TB_LEVELS)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_pool_base_frame(cfg_pool_base_frame),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_virt_addr       (in_virt_addr),
    .in_phys_addr       (in_phys_addr),
    .in_attr_flags      (in_attr_flags),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_tables_added   (out_tables_added)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Bound the run; a hang counts as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Check every result transaction against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_status, out_tables_added);
  end

  // Receiver: random ready bursts, one long hold-off on request, none when quiet.
  initial begin
    out_ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Present one request and hold it until the transaction completes; note it then.
  task automatic send_item(logic [47:0] va, logic [47:0] pa, logic [63:0] fl);
    in_valid      <= 1'b1;
    in_virt_addr  <= va;
    in_phys_addr  <= pa;
    in_attr_flags <= fl;
    do @(posedge clk); while (!in_ready);
    sb.note_request(va, pa, fl);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_pool_base(logic [35:0] v);
    cfg_valid           <= 1'b1;
    cfg_pool_base_frame <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_base(v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wide random value, with all zeros and all ones now and then.
  function automatic logic [63:0] rand_wide();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 64'h0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Mostly reuse leaf tables already on a mapped path; sometimes repeat a page
  // or send a fully random address.
  function automatic logic [47:0] pick_va();
    logic [63:0] r;
    logic [47:0] m;
    int unsigned sel;
    r = {$urandom, $urandom};
    sel = $urandom_range(0, 99);
    if (sb.mapped_pages.size() == 0 || sel >= 80) return r[47:0];
    m = sb.mapped_pages[$urandom_range(0, sb.mapped_pages.size() - 1)];
    if (sel < 65) return {m[47:21], r[20:0]};
    return {m[47:12], r[11:0]};
  endfunction

  task automatic random_phase(int n);
    logic [63:0] pa;
    logic [63:0] fl;
    for (int i = 0; i < n; i++) begin
      if (!quiet && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 14));
      pa = rand_wide();
      fl = rand_wide();
      send_item(pick_va(), pa[47:0], fl);
    end
  endtask

  initial begin
    logic [63:0] r;
    sb       = new();
    hold_req = 1'b0;
    quiet    = 1'b0;
    rst_n               <= 1'b0;
    cfg_valid           <= 1'b0;
    cfg_pool_base_frame <= '0;
    in_valid            <= 1'b0;
    in_virt_addr        <= '0;
    in_phys_addr        <= '0;
    in_attr_flags       <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Top frame number: pool frames wrap through zero.
    write_pool_base(BASE_MAX);

    // Directed: new full path, repeat, top address, then new tables at each
    // level until the pool runs dry part way through a walk.
    send_item(48'h0, 48'h0, 64'h0);
    send_item(48'h0, '1, '1);
    send_item('1, '1, '1);
    send_item(48'h0000_0000_1000, 48'h1234_5678_9000, 64'h0040_0000_0000_0040);
    send_item(48'h0000_0020_0000, 48'h0, '1);
    send_item(48'h0000_4000_0000, '1, 64'h0);
    send_item(48'h0000_4020_0000, 48'hABCD_EF01_2000, 64'h8000_0000_0000_0000);
    send_item(48'h0100_0000_0000, 48'h0, 64'h0);
    send_item(48'h0180_0000_0000, 48'h0, 64'h0);
    send_item(48'h0100_0020_0000, 48'h0, 64'h0);
    send_item(48'h0000_001F_F000, 48'h0000_0000_0FFF, 64'h5555_5555_5555_5555);
    send_item(48'h0000_0000_2FFF, 48'hAAAA_AAAA_A000, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(48'h0000_0000_3000, 48'h0, 64'h0);
    send_item(48'hFFFF_FFFF_E000, 48'h0, 64'h0);
    wait_results_done();

    // Pool base moved away: existing table pointers go stale.
    write_pool_base(36'h8_0000_0000);
    send_item(48'h0, 48'h0, 64'h0);
    send_item(48'h0000_0000_5000, '1, '1);
    wait_results_done();

    write_pool_base(BASE_MAX);
    random_phase(300);
    // Stall the receiver long enough that the block backs up into the input.
    hold_req = 1'b1;
    random_phase(300);
    // Pause the sender until everything is back, then carry on.
    wait_results_done();
    random_phase(300);
    wait_results_done();

    // Zero base: old pointers now name neighboring tables.
    write_pool_base(36'h0);
    random_phase(200);
    wait_results_done();

    r = {$urandom, $urandom};
    write_pool_base(r[35:0]);
    random_phase(200);
    wait_results_done();

    write_pool_base(BASE_MAX);
    random_phase(100);
    quiet = 1'b1;
    random_phase(150);
    wait_results_done();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// File: page_table_map_insert.f
hdl/ptmi_pkg.sv
hdl/ptmi_ram.sv
hdl/ptmi_dp.sv
hdl/ptmi_ctrl.sv
hdl/page_table_map_insert.sv
test/tb_top.sv
